[sv/rwl_pkg.sv]
package rwl_pkg;

	// Default widths of thread ids and counters
	localparam int THREAD_ID_BITS_DEF = 8;
	localparam int COUNT_BITS_DEF     = 8;

	// Request command codes
	typedef enum logic [2:0] {
		CMD_ENTER_READ  = 3'd0,
		CMD_ENTER_WRITE = 3'd1,
		CMD_RETRY_WRITE = 3'd2,
		CMD_LEAVE       = 3'd3,
		CMD_TRY_UPGRADE = 3'd4,
		CMD_DOWNGRADE   = 3'd5
	} cmd_t;

	// Response status codes
	typedef enum logic [1:0] {
		ST_GRANTED = 2'd0,
		ST_WAIT    = 2'd1,
		ST_REFUSED = 2'd2,
		ST_ERROR   = 2'd3
	} status_t;

	// Lock mode
	typedef enum logic [1:0] {
		MODE_FREE  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_WRITE = 2'd2
	} mode_t;

endpackage

[sv/rwl_req_if.sv]
interface rwl_req_if #(
	parameter int THREAD_ID_BITS = rwl_pkg::THREAD_ID_BITS_DEF
);
	logic                      valid;
	logic                      ready;
	logic [2:0]                command;
	logic [THREAD_ID_BITS-1:0] thread_id;

	modport source (output valid, output command, output thread_id, input ready);
	modport sink   (input valid, input command, input thread_id, output ready);
endinterface

[sv/rwl_rsp_if.sv]
interface rwl_rsp_if #(
	parameter int COUNT_BITS = rwl_pkg::COUNT_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            status;
	logic                  wake_one_writer;
	logic                  wake_all_readers;
	logic [1:0]            lock_mode;
	logic [COUNT_BITS-1:0] reader_total;

	modport source (
		output valid, output status, output wake_one_writer, output wake_all_readers,
		output lock_mode, output reader_total, input ready
	);
	modport sink (
		input valid, input status, input wake_one_writer, input wake_all_readers,
		input lock_mode, input reader_total, output ready
	);
endinterface

[sv/rwl_cfg_if.sv]
interface rwl_cfg_if;
	logic valid;
	logic ready;
	logic data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[sv/reader_writer_lock_unit.sv]
// Channel | Modport | Carries                                   | Accepted when
// req     | sink    | command, thread_id                        | valid && ready
// rsp     | source  | status, wake flags, lock_mode, reader_total| valid && ready
// cfg     | sink    | data = recursion_allowed                  | valid && ready (ready = 1)
//
// Each request passes through an input register, is decided combinationally
// against the lock state, and lands in the response register, one request
// per cycle sustained while the response is not stalled.
// Reset clears the lock to unlocked with all counters, owner and recursion_allowed zero.
// A stalled response holds the response register; the input register still
// takes a new request while its own slot is empty.
module reader_writer_lock_unit #(
	parameter int THREAD_ID_BITS = rwl_pkg::THREAD_ID_BITS_DEF,
	parameter int COUNT_BITS     = rwl_pkg::COUNT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	rwl_req_if.sink   req,
	rwl_rsp_if.source rsp,
	rwl_cfg_if.sink   cfg
);
	import rwl_pkg::*;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_ZERO = '0;
	localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);

	// Input stage
	logic                      valid_s1;
	logic [2:0]                cmd_s1;
	logic [THREAD_ID_BITS-1:0] tid_s1;
	logic                      advance;

	// Lock state
	mode_t                     mode_q;
	logic [COUNT_BITS-1:0]     readers_q;
	logic [COUNT_BITS-1:0]     waiters_q;
	logic [THREAD_ID_BITS-1:0] owner_q;
	logic                      owner_valid_q;
	logic [COUNT_BITS-1:0]     depth_q;
	logic                      recursion_allowed_q;

	// Next state and result
	mode_t                     mode_d;
	logic [COUNT_BITS-1:0]     readers_d;
	logic [COUNT_BITS-1:0]     waiters_d;
	logic [THREAD_ID_BITS-1:0] owner_d;
	logic                      owner_valid_d;
	logic [COUNT_BITS-1:0]     depth_d;
	status_t                   status_d;
	logic                      wake_w_d;
	logic                      wake_r_d;
	logic                      locked;
	logic                      owned;

	// Response register
	logic                      out_valid_q;
	status_t                   status_q;
	logic                      wake_w_q;
	logic                      wake_r_q;
	mode_t                     out_mode_q;
	logic [COUNT_BITS-1:0]     out_readers_q;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// Capture a request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			cmd_s1 <= req.command;
			tid_s1 <= req.thread_id;
		end
	end

	// Decide the request against the current lock state
	always_comb begin
		locked        = (mode_q == MODE_READ) || (mode_q == MODE_WRITE);
		owned         = owner_valid_q && (owner_q == tid_s1) && (mode_q == MODE_WRITE);
		mode_d        = mode_q;
		readers_d     = readers_q;
		waiters_d     = waiters_q;
		owner_d       = owner_q;
		owner_valid_d = owner_valid_q;
		depth_d       = depth_q;
		status_d      = ST_GRANTED;
		wake_w_d      = 1'b0;
		wake_r_d      = 1'b0;
		case (cmd_s1)
			CMD_ENTER_READ: begin
				if (mode_q == MODE_WRITE || waiters_q != COUNT_ZERO) begin
					status_d = ST_WAIT;
				end else if (readers_q == COUNT_MAX) begin
					status_d = ST_ERROR;
				end else begin
					readers_d = readers_q + COUNT_ONE;
					mode_d    = MODE_READ;
				end
			end
			CMD_ENTER_WRITE: begin
				if (owned) begin
					if (!recursion_allowed_q || depth_q == COUNT_MAX) begin
						status_d = ST_ERROR;
					end else begin
						depth_d = depth_q + COUNT_ONE;
					end
				end else if (!locked) begin
					mode_d        = MODE_WRITE;
					owner_d       = tid_s1;
					owner_valid_d = 1'b1;
					depth_d       = COUNT_ZERO;
				end else if (waiters_q == COUNT_MAX) begin
					status_d = ST_ERROR;
				end else begin
					waiters_d = waiters_q + COUNT_ONE;
					status_d  = ST_WAIT;
				end
			end
			CMD_RETRY_WRITE: begin
				if (waiters_q == COUNT_ZERO) begin
					status_d = ST_ERROR;
				end else if (locked) begin
					status_d = ST_WAIT;
				end else begin
					waiters_d     = waiters_q - COUNT_ONE;
					mode_d        = MODE_WRITE;
					owner_d       = tid_s1;
					owner_valid_d = 1'b1;
					depth_d       = COUNT_ZERO;
				end
			end
			CMD_LEAVE: begin
				if (mode_q == MODE_READ) begin
					if (readers_q == COUNT_ZERO) begin
						status_d = ST_ERROR;
					end else begin
						readers_d = readers_q - COUNT_ONE;
						if (readers_q == COUNT_ONE) begin
							mode_d   = MODE_FREE;
							wake_w_d = (waiters_q != COUNT_ZERO);
						end
					end
				end else if (owned) begin
					if (depth_q != COUNT_ZERO) begin
						if (!recursion_allowed_q) begin
							status_d = ST_ERROR;
						end else begin
							depth_d = depth_q - COUNT_ONE;
						end
					end else begin
						mode_d        = MODE_FREE;
						owner_d       = '0;
						owner_valid_d = 1'b0;
						wake_w_d      = (waiters_q != COUNT_ZERO);
						wake_r_d      = (waiters_q == COUNT_ZERO);
					end
				end else begin
					status_d = ST_ERROR;
				end
			end
			CMD_TRY_UPGRADE: begin
				if (!locked) begin
					status_d = ST_ERROR;
				end else if (mode_q == MODE_READ && readers_q == COUNT_ONE &&
				             waiters_q == COUNT_ZERO) begin
					readers_d     = COUNT_ZERO;
					mode_d        = MODE_WRITE;
					owner_d       = tid_s1;
					owner_valid_d = 1'b1;
					depth_d       = COUNT_ZERO;
				end else begin
					status_d = ST_REFUSED;
				end
			end
			CMD_DOWNGRADE: begin
				if (!owned || depth_q != COUNT_ZERO || readers_q == COUNT_MAX) begin
					status_d = ST_ERROR;
				end else begin
					readers_d     = readers_q + COUNT_ONE;
					mode_d        = MODE_READ;
					owner_d       = '0;
					owner_valid_d = 1'b0;
					wake_r_d      = 1'b1;
				end
			end
			default: begin
				status_d = ST_ERROR;
			end
		endcase
	end

	// Update the lock state and the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q              <= MODE_FREE;
			readers_q           <= '0;
			waiters_q           <= '0;
			owner_q             <= '0;
			owner_valid_q       <= 1'b0;
			depth_q             <= '0;
			recursion_allowed_q <= 1'b0;
		end else begin
			if (advance) begin
				mode_q        <= mode_d;
				readers_q     <= readers_d;
				waiters_q     <= waiters_d;
				owner_q       <= owner_d;
				owner_valid_q <= owner_valid_d;
				depth_q       <= depth_d;
			end
			if (cfg.valid) begin
				recursion_allowed_q <= cfg.data;
			end
		end
	end

	// Hold the response until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || rsp.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q      <= status_d;
			wake_w_q      <= wake_w_d;
			wake_r_q      <= wake_r_d;
			out_mode_q    <= mode_d;
			out_readers_q <= readers_d;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.status           = status_q;
	assign rsp.wake_one_writer  = wake_w_q;
	assign rsp.wake_all_readers = wake_r_q;
	assign rsp.lock_mode        = out_mode_q;
	assign rsp.reader_total     = out_readers_q;

endmodule
